@@ sv/packet_word_scrambler_assert.svh @@
// Assertion macros for the packet word scrambler.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef PACKET_WORD_SCRAMBLER_ASSERT_SVH
`define PACKET_WORD_SCRAMBLER_ASSERT_SVH

// Same-cycle implication, inactive while in reset.
`define PWS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, inactive while in reset.
`define PWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pws_pkg.sv @@
// Package for the packet word scrambler: group kind codes, constants,
// the beat struct passed between stages and the per-byte body key step.
`default_nettype none

package pws_pkg;

	localparam logic [1:0] KIND_PROTO = 2'd1;
	localparam logic [1:0] KIND_BODY  = 2'd2;

	localparam logic [31:0] KEY_INIT     = 32'h04C4_78BD;
	localparam logic [31:0] KEY_MUL      = 32'h0024_1AE7;
	localparam logic [31:0] KEY_ADD      = 32'h0015_DCB2;
	localparam logic [31:0] PROTO_MUL_EN = 32'hA7F0_753B;
	localparam logic [31:0] PROTO_MUL_DE = 32'hAAF2_9BF3;
	localparam logic [15:0] PROTO_LOW    = 16'h0201;

	// Only key bits 15:8 ever reach the data, and low product bits depend only
	// on low operand bits, so the key is kept to its low 16 bits.
	typedef struct packed {
		logic        body;
		logic        dir;
		logic [15:0] key;
		logic [31:0] data;
	} pws_beat_t;

	// For a body beat: scramble the byte in data[7:0], rotate it to the top, advance the key.
	// After four steps the bytes are back in their original order.
	function automatic pws_beat_t body_step(input pws_beat_t b);
		logic [7:0]  in_b;
		logic [7:0]  out_b;
		logic [7:0]  c;
		logic [15:0] sum;
		logic [15:0] prod;
		pws_beat_t   r;
		in_b  = b.data[7:0];
		out_b = in_b ^ b.key[15:8];
		c     = b.dir ? in_b : out_b;
		sum   = {8'd0, c} + b.key;
		prod  = sum * KEY_MUL[15:0];
		r     = b;
		if (b.body) begin
			r.key  = prod + KEY_ADD[15:0];
			r.data = {out_b, b.data[31:8]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/pws_front.sv @@
// Entry stage of the packet word scrambler: protocol word multiply and the
// first body byte step, registered as stage 1. Uses pws_pkg.
`default_nettype none

module pws_front import pws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        dir,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] group_word,
	input  wire logic [1:0]  group_kind,
	output logic             s1_valid,
	input  wire logic        s1_ready,
	output pws_beat_t        s1_beat
);

	logic        valid_s1;
	pws_beat_t   beat_s1;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] proto_word;
	pws_beat_t   entry;
	pws_beat_t   entry_next;

	// One shared multiplier: decode keeps the upper half of w*K,
	// encode multiplies the low half shifted up with the fixed low bytes.
	always_comb begin
		mul_a = dir ? group_word : {group_word[15:0], PROTO_LOW};
		mul_b = dir ? PROTO_MUL_DE : PROTO_MUL_EN;
		mul_p = mul_a * mul_b;
		proto_word = dir ? {16'd0, mul_p[31:16]} : mul_p;
	end

	// Body step runs on the raw word; the protocol result is muxed in after it,
	// so the two multipliers sit side by side rather than in series.
	always_comb begin
		entry.body = (group_kind == KIND_BODY);
		entry.dir  = dir;
		entry.key  = KEY_INIT[15:0];
		entry.data = group_word;
		entry_next = body_step(entry);
		if (group_kind == KIND_PROTO) begin
			entry_next.data = proto_word;
		end
	end

	assign in_ready = !valid_s1 || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= entry_next;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_beat  = beat_s1;

endmodule

`default_nettype wire

@@ sv/pws_body.sv @@
// Stages 2 to 4 of the packet word scrambler: the remaining three body byte
// steps, the last one feeding the output register. Uses pws_pkg.
`default_nettype none

module pws_body import pws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s1_valid,
	output logic             s1_ready,
	input  pws_beat_t        s1_beat,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      result_word
);

	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	pws_beat_t beat_s2;
	pws_beat_t beat_s3;
	pws_beat_t beat_s4;
	logic      rdy2;
	logic      rdy3;
	logic      rdy4;

	// A stage loads when it is empty or its content moves on this cycle.
	assign rdy4 = !valid_s4 || result_ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy2) begin
				valid_s2 <= s1_valid;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && rdy2) begin
			beat_s2 <= body_step(s1_beat);
		end
		if (valid_s2 && rdy3) begin
			beat_s3 <= body_step(beat_s2);
		end
		if (valid_s3 && rdy4) begin
			beat_s4 <= body_step(beat_s3);
		end
	end

	assign s1_ready     = rdy2;
	assign result_valid = valid_s4;
	assign result_word  = beat_s4.data;

endmodule

`default_nettype wire

@@ sv/packet_word_scrambler.sv @@
// Packet word scrambler: one 32-bit packet group in, one transformed group out.
// Input channel: group_word/group_kind with group_valid/group_ready. Kind 0 and
// the unused kind 3 pass through, kind 1 is the protocol word at offset 10
// (multiplicative transform), kind 2 is a body group XORed byte by byte with a
// rolling key that restarts for every group.
// Output channel: result_word with result_valid/result_ready.
// cfg_wr_en/cfg_wr_data write the direction (0 scramble, 1 unscramble); write
// it only while nothing is in flight. Each beat samples it on entry.
// An accepted beat passes through four register stages and shows on result_valid from the
// last: the entry stage with the first key step, then one key step per remaining body
// byte, each set by one 16-bit key multiply.
// Throughput: one beat per cycle while result_ready stays high.
// Reset (arst_n low) empties all four stages and sets direction to scramble.
// When result_ready is low the output stage holds its beat and earlier stages
// keep filling; group_ready drops only once all four stages are full.
// Depends on pws_pkg, pws_front, pws_body and packet_word_scrambler_assert.svh.
`default_nettype none

module packet_word_scrambler import pws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        group_valid,
	output logic             group_ready,
	input  wire logic [31:0] group_word,
	input  wire logic [1:0]  group_kind,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      result_word
);

`include "packet_word_scrambler_assert.svh"

	logic      direction_q;
	logic      s1_valid;
	logic      s1_ready;
	pws_beat_t s1_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	pws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.dir        (direction_q),
		.in_valid   (group_valid),
		.in_ready   (group_ready),
		.group_word (group_word),
		.group_kind (group_kind),
		.s1_valid   (s1_valid),
		.s1_ready   (s1_ready),
		.s1_beat    (s1_beat)
	);

	pws_body u_body (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1_ready     (s1_ready),
		.s1_beat      (s1_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	`PWS_ASSERT_NEXT(a_accept_fills_s1, group_valid && group_ready, s1_valid, "beat lost")
	`PWS_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_beat), "s1 moved")
	`PWS_ASSERT_NOW(a_full_stall, !group_ready, s1_valid && !s1_ready && result_valid, "bad stall")

endmodule

`default_nettype wire

@@ bench/tb_packet_word_scrambler.sv @@
// Testbench for packet_word_scrambler: directed and random groups in both directions,
// with random idling on both channels, checked against an in-bench predictor.
// Depends on pws_pkg and the packet_word_scrambler RTL.
`default_nettype none

module tb_packet_word_scrambler import pws_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_PASS   = 2'd0;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic       DIR_SCRAMBLE   = 1'b0;
	localparam logic       DIR_UNSCRAMBLE = 1'b1;
	localparam int PIPE_DEPTH  = 4;
	localparam int IDLE_PCT    = 31;
	localparam int MAX_REPORTS = 30;

	typedef struct {
		logic [31:0] word;
		logic [1:0]  kind;
		logic [31:0] result;
	} group_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        group_valid = 1'b0;
	logic        group_ready;
	logic [31:0] group_word = '0;
	logic [1:0]  group_kind = KIND_PASS;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] result_word;

	group_expect_t pending_groups[$];
	logic          cur_direction = DIR_SCRAMBLE;
	bit            src_idle_on = 1'b1;
	bit            sink_idle_on = 1'b1;
	int            err_count = 0;

	packet_word_scrambler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.group_valid  (group_valid),
		.group_ready  (group_ready),
		.group_word   (group_word),
		.group_kind   (group_kind),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	always #2 clk = ~clk;

	// Expected output word for one group under the given direction.
	function automatic logic [31:0] scramble_group(input logic [31:0] w, input logic [1:0] k,
			input logic dir);
		logic [31:0] key;
		logic [31:0] acc;
		logic [31:0] prod;
		logic [7:0]  in_b;
		logic [7:0]  out_b;
		logic [7:0]  cipher;
		case (k)
			KIND_PROTO: begin
				if (dir == DIR_UNSCRAMBLE) begin
					prod = w * PROTO_MUL_DE;
					acc  = {16'd0, prod[31:16]};
				end else begin
					prod = {w[15:0], PROTO_LOW};
					acc  = prod * PROTO_MUL_EN;
				end
			end
			KIND_BODY: begin
				key = KEY_INIT;
				acc = '0;
				for (int b = 0; b < 4; b++) begin
					in_b   = w[8*b +: 8];
					out_b  = in_b ^ key[15:8];
					cipher = (dir == DIR_UNSCRAMBLE) ? in_b : out_b;
					key    = ({24'd0, cipher} + key) * KEY_MUL + KEY_ADD;
					acc[8*b +: 8] = out_b;
				end
			end
			default: acc = w;
		endcase
		return acc;
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, what);
	endtask

	// One beat into the block; valid stays up after acceptance so the next call can reuse it.
	task automatic send_group(input logic [31:0] w, input logic [1:0] k);
		group_expect_t e;
		while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
			group_valid <= 1'b0;
			@(posedge clk);
		end
		group_valid <= 1'b1;
		group_word  <= w;
		group_kind  <= k;
		@(posedge clk);
		while (!group_ready)
			@(posedge clk);
		e.word   = w;
		e.kind   = k;
		e.result = scramble_group(w, k, cur_direction);
		pending_groups.push_back(e);
	endtask

	// Drop valid and let every expected beat come out.
	task automatic drain_groups();
		group_valid <= 1'b0;
		while (pending_groups.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_direction(input logic dir);
		drain_groups();
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		cur_direction = dir;
	endtask

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(9);
		if (r < 2)
			return KIND_PASS;
		else if (r < 5)
			return KIND_PROTO;
		else if (r < 9)
			return KIND_BODY;
		return KIND_UNUSED;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(31);
			3: return ~(32'h1 << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_groups(input int count, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				drain_groups();
			send_group(pick_word(), pick_kind());
		end
	endtask

	// Extremes, every kind, upper protocol half dropped, key restart per group.
	task automatic send_directed_groups();
		send_group(32'h0000_0000, KIND_PASS);
		send_group(32'hFFFF_FFFF, KIND_PASS);
		send_group(32'hA5C3_0F01, KIND_UNUSED);
		send_group(32'hFFFF_FFFF, KIND_UNUSED);
		send_group(32'h0000_0000, KIND_PROTO);
		send_group(32'hFFFF_FFFF, KIND_PROTO);
		send_group(32'h1234_ABCD, KIND_PROTO);
		send_group(32'h0000_ABCD, KIND_PROTO);
		send_group(32'h0000_0000, KIND_BODY);
		send_group(32'hFFFF_FFFF, KIND_BODY);
		send_group(32'h8000_0001, KIND_BODY);
		send_group(32'h8000_0001, KIND_BODY);
	endtask

	// Runs on the direction left by reset.
	task automatic test_directed_scramble();
		send_directed_groups();
	endtask

	task automatic test_directed_unscramble();
		set_direction(DIR_UNSCRAMBLE);
		send_directed_groups();
	endtask

	task automatic test_random_scramble();
		set_direction(DIR_SCRAMBLE);
		send_random_groups(350, -1);
	endtask

	task automatic test_random_unscramble_with_drain();
		set_direction(DIR_UNSCRAMBLE);
		send_random_groups(350, 175);
	endtask

	task automatic test_back_to_back();
		drain_groups();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_random_groups(300, -1);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	task automatic test_random_rescramble();
		set_direction(DIR_SCRAMBLE);
		send_random_groups(250, -1);
	endtask

	// Result side: random backpressure, compare each beat with the oldest expectation.
	initial begin : result_sink
		group_expect_t e;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (pending_groups.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat %h", result_word));
				end else begin
					e = pending_groups.pop_front();
					if (result_word !== e.result)
						report_mismatch($sformatf("kind %0d word %h: result %h, want %h",
							e.kind, e.word, result_word, e.result));
				end
			end
			result_ready <= sink_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
		end
	end

	initial begin : run_limit
		#2ms;
		$display("tb_packet_word_scrambler: errors");
		$finish;
	end

	initial begin : main_seq
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_scramble();
		test_directed_unscramble();
		test_random_scramble();
		test_random_unscramble_with_drain();
		test_back_to_back();
		test_random_rescramble();
		drain_groups();
		// watch for stray beats after the last expected one
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (err_count == 0)
			$display("tb_packet_word_scrambler: clean");
		else
			$display("tb_packet_word_scrambler: errors");
		$finish;
	end

endmodule

`default_nettype wire
